[rtl/core/fpfa_pkg.sv]
// Shared types and codes for the fixed partition fit allocator.
package fpfa_pkg;

    // item function codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_ALLOC = 2'd2;

    // fit policy codes
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // configuration register select (paddr bit 2)
    localparam int         ADDR_W         = 3;
    localparam logic       REG_FIT_POLICY = 1'b0;
    localparam logic       REG_HOLE_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  hole_slot;
        logic [15:0] hole_bytes;
        logic [15:0] req_size;
    } fpfa_in_t;

    typedef struct packed {
        logic       found;
        logic [4:0] hole_index;
    } fpfa_out_t;

    typedef struct packed {
        logic init;       // forget the current best candidate
        logic cmp_en;     // a hole entry is on the compare inputs
        logic cand_free;  // that entry is not marked taken
    } fpfa_fit_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } fpfa_state_t;

endpackage

[rtl/core/fpfa_hole_mem.sv]
// Hole size memory: one write port, one registered read port.
module fpfa_hole_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/fpfa_fit_unit.sv]
// Shared compare unit: tracks the best fitting hole over a scan.
module fpfa_fit_unit #(
    parameter int SW = 16,
    parameter int IW = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fpfa_pkg::fpfa_fit_ctrl_t ctrl,
    input  logic [1:0]              policy,
    input  logic [SW-1:0]           want,
    input  logic [SW-1:0]           cand_size,
    input  logic [IW-1:0]           cand_idx,
    output logic                    have,
    output logic [IW-1:0]           best_idx
);

    logic          have_reg, have_next;
    logic [IW-1:0] best_i_reg, best_i_next;
    logic [SW-1:0] best_s_reg, best_s_next;
    logic          fits;
    logic          take;

    always_comb
    begin
        fits = ctrl.cand_free && (cand_size >= want);
        take = 1'b0;
        priority if (policy == fpfa_pkg::POL_FIRST)
        begin
            take = fits && !have_reg;
        end
        else if (policy == fpfa_pkg::POL_BEST)
        begin
            take = fits && (!have_reg || cand_size < best_s_reg);
        end
        else if (policy == fpfa_pkg::POL_WORST)
        begin
            take = fits && (cand_size != '0) && (!have_reg || cand_size > best_s_reg);
        end
        else
        begin
            take = 1'b0;  // unused policy never picks
        end

        have_next   = have_reg;
        best_i_next = best_i_reg;
        best_s_next = best_s_reg;
        if (ctrl.init)
        begin
            have_next = 1'b0;
        end
        else if (ctrl.cmp_en && take)
        begin
            have_next   = 1'b1;
            best_i_next = cand_idx;
            best_s_next = cand_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_i_reg <= best_i_next;
        best_s_reg <= best_s_next;
    end

    assign have     = have_reg;
    assign best_idx = best_i_reg;

endmodule

[rtl/core/fixed_partition_fit_allocator_core.sv]
// Fixed partition fit allocator: sequencer, taken marks, config port.
// Load, clear, unused code: accepted in ST_IDLE, then ST_PUSH registers the result once the output is free.
// Allocate: ST_SCAN reads N = min(hole_count, MAX_HOLES) holes, one hole per
// cycle through the memory read port and the shared compare unit, then ST_PUSH.
// A new item is taken only in ST_IDLE; it is taken while the last result waits.
// Reset (rst_n, async low) clears taken marks and config; sizes unset.
module fixed_partition_fit_allocator_core #(
    parameter int MAX_HOLES  = 32,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  fpfa_pkg::fpfa_in_t            req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output fpfa_pkg::fpfa_out_t           rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fpfa_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CW = $clog2(MAX_HOLES + 1);

    fpfa_pkg::fpfa_state_t state_reg, state_next;

    logic [1:0]            fit_policy_reg;
    logic [5:0]            hole_count_reg;
    logic [MAX_HOLES-1:0]  taken_reg, taken_next;
    logic [SIZE_WIDTH-1:0] want_reg, want_next;
    logic [CW-1:0]         lim_reg, lim_next;
    logic [CW-1:0]         rd_cnt_reg, rd_cnt_next;
    logic                  pend_reg, pend_next;
    logic [IW-1:0]         pend_idx_reg, pend_idx_next;
    logic                  res_found_reg, res_found_next;
    logic [4:0]            res_idx_reg, res_idx_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    fpfa_pkg::fpfa_out_t   rsp_reg, rsp_next;

    logic                  mem_we, mem_re;
    logic [IW-1:0]         mem_waddr;
    logic [SIZE_WIDTH-1:0] mem_rdata;
    fpfa_pkg::fpfa_fit_ctrl_t fit_ctrl;
    logic                  fit_have;
    logic [IW-1:0]         fit_best;
    logic                  cfg_we;
    logic                  more;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= 2'd0;
            hole_count_reg <= 6'd0;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == fpfa_pkg::REG_FIT_POLICY)
            begin
                fit_policy_reg <= pwdata[1:0];
            end
            else
            begin
                hole_count_reg <= pwdata[5:0];
            end
        end
    end

    assign prdata = (paddr[2] == fpfa_pkg::REG_HOLE_COUNT) ? {26'd0, hole_count_reg}
                                                            : {30'd0, fit_policy_reg};

    // ---------------- datapath parts ----------------
    assign mem_waddr = IW'(req.hole_slot);

    fpfa_hole_mem #(
        .DEPTH (MAX_HOLES),
        .WIDTH (SIZE_WIDTH),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (SIZE_WIDTH'(req.hole_bytes)),
        .re    (mem_re),
        .raddr (rd_cnt_reg[IW-1:0]),
        .rdata (mem_rdata)
    );

    fpfa_fit_unit #(
        .SW (SIZE_WIDTH),
        .IW (IW)
    ) u_fit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fit_ctrl),
        .policy    (fit_policy_reg),
        .want      (want_reg),
        .cand_size (mem_rdata),
        .cand_idx  (pend_idx_reg),
        .have      (fit_have),
        .best_idx  (fit_best)
    );

    // ---------------- sequencer ----------------
    assign more = (rd_cnt_reg < lim_reg);

    always_comb
    begin
        state_next     = state_reg;
        taken_next     = taken_reg;
        want_next      = want_reg;
        lim_next       = lim_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        req_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        fit_ctrl       = '0;
        fit_ctrl.cand_free = !taken_reg[pend_idx_reg];

        unique case (state_reg)
            fpfa_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    res_found_next = 1'b0;
                    res_idx_next   = 5'd0;
                    state_next     = fpfa_pkg::ST_PUSH;
                    unique case (req.func)
                        fpfa_pkg::FUNC_LOAD:
                        begin
                            mem_we = (32'(req.hole_slot) < MAX_HOLES);
                        end
                        fpfa_pkg::FUNC_CLEAR:
                        begin
                            taken_next = '0;
                        end
                        fpfa_pkg::FUNC_ALLOC:
                        begin
                            want_next   = SIZE_WIDTH'(req.req_size);
                            rd_cnt_next = '0;
                            fit_ctrl.init = 1'b1;
                            if (32'(hole_count_reg) > MAX_HOLES)
                            begin
                                lim_next = CW'(MAX_HOLES);
                            end
                            else
                            begin
                                lim_next = CW'(hole_count_reg);
                            end
                            state_next = fpfa_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            // unused code: no table change; a not-found result follows
                        end
                    endcase
                end
            end

            fpfa_pkg::ST_SCAN:
            begin
                // read of entry k overlaps the compare of entry k-1
                fit_ctrl.cmp_en = pend_reg;
                if (more)
                begin
                    mem_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_cnt_reg[IW-1:0];
                    rd_cnt_next   = rd_cnt_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    res_found_next = fit_have;
                    res_idx_next   = fit_have ? 5'(fit_best) : 5'd0;
                    if (fit_have)
                    begin
                        taken_next[fit_best] = 1'b1;
                    end
                    state_next = fpfa_pkg::ST_PUSH;
                end
            end

            fpfa_pkg::ST_PUSH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.found      = res_found_reg;
                    rsp_next.hole_index = res_idx_reg;
                    state_next          = fpfa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fpfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpfa_pkg::ST_IDLE;
            taken_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            taken_reg     <= taken_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg      <= want_next;
        lim_reg       <= lim_next;
        rd_cnt_reg    <= rd_cnt_next;
        pend_idx_reg  <= pend_idx_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[bench/fixed_partition_fit_allocator_core_tb.sv]
// Self-checking bench for the fit allocator: directed fits, random phases, backpressure.
`timescale 1ns / 100ps

module fixed_partition_fit_allocator_core_tb;

    localparam int         HOLES       = 32;
    localparam int         HOLD_CYCLES = 400;
    localparam int         IDLE_LIMIT  = 3000;
    localparam logic [1:0] POL_UNUSED  = 2'd3;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_ready;
    fpfa_pkg::fpfa_in_t            req;
    logic                          rsp_valid;
    logic                          rsp_ready;
    fpfa_pkg::fpfa_out_t           rsp;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [fpfa_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    // predictor state
    logic [15:0]         hole_sizes [HOLES];
    logic [HOLES-1:0]    held_mask;
    logic [1:0]          cur_policy;
    logic [5:0]          cur_count;

    fpfa_pkg::fpfa_out_t grant_q [$];
    int                  errors;
    int                  idle_cycles;
    bit                  hold_off;
    bit                  calm;

    fixed_partition_fit_allocator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one item to the predicted table and returns the expected grant.
    function automatic fpfa_pkg::fpfa_out_t fit_grant(input fpfa_pkg::fpfa_in_t it);
        fpfa_pkg::fpfa_out_t r;
        int          lim;
        bit          have;
        int          pick;
        logic [15:0] pick_size;
        logic [15:0] s;
        r = '0;
        have = 1'b0;
        pick = 0;
        pick_size = '0;
        case (it.func)
            fpfa_pkg::FUNC_LOAD:  hole_sizes[it.hole_slot] = it.hole_bytes;
            fpfa_pkg::FUNC_CLEAR: held_mask = '0;
            fpfa_pkg::FUNC_ALLOC:
            begin
                lim = (cur_count > HOLES) ? HOLES : int'(cur_count);
                for (int i = 0; i < lim; i++)
                begin
                    s = hole_sizes[i];
                    if (!held_mask[i] && s >= it.req_size)
                    begin
                        if (cur_policy == fpfa_pkg::POL_FIRST)
                        begin
                            if (!have)
                            begin
                                have = 1'b1;
                                pick = i;
                            end
                        end
                        else if (cur_policy == fpfa_pkg::POL_BEST)
                        begin
                            if (!have || s < pick_size)
                            begin
                                have = 1'b1;
                                pick = i;
                                pick_size = s;
                            end
                        end
                        else if (cur_policy == fpfa_pkg::POL_WORST)
                        begin
                            if (s != 0 && (!have || s > pick_size))
                            begin
                                have = 1'b1;
                                pick = i;
                                pick_size = s;
                            end
                        end
                    end
                end
                if (have)
                begin
                    held_mask[pick] = 1'b1;
                    r.found = 1'b1;
                    r.hole_index = 5'(pick);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic fpfa_pkg::fpfa_in_t rand_item();
        fpfa_pkg::fpfa_in_t it;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 58)
            it.func = fpfa_pkg::FUNC_ALLOC;
        else if (roll < 84)
            it.func = fpfa_pkg::FUNC_LOAD;
        else if (roll < 96)
            it.func = fpfa_pkg::FUNC_CLEAR;
        else
            it.func = FUNC_UNUSED;
        it.hole_slot  = 5'($urandom);
        it.hole_bytes = rand_size();
        it.req_size   = rand_size();
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic send_item(input fpfa_pkg::fpfa_in_t it);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req = it;
        req_valid = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        grant_q.push_back(fit_grant(it));
    endtask

    task automatic issue(input logic [1:0] func, input logic [4:0] slot,
                         input logic [15:0] bytes, input logic [15:0] want);
        fpfa_pkg::fpfa_in_t it;
        it.func = func;
        it.hole_slot = slot;
        it.hole_bytes = bytes;
        it.req_size = want;
        send_item(it);
    endtask

    // wait until every outstanding item has produced its result
    task automatic settle();
        @(negedge clk);
        req_valid = 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(input logic sel, input logic [31:0] value);
        settle();
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {sel, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (sel == fpfa_pkg::REG_FIT_POLICY)
            cur_policy = value[1:0];
        else
            cur_count = value[5:0];
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata != value)
            report_mismatch($sformatf("readback reg %0d: got %0h want %0h",
                                      sel, prdata, value));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic test_empty_scan();
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd0);
        issue(FUNC_UNUSED, 5'd31, 16'hFFFF, 16'hFFFF);
        issue(fpfa_pkg::FUNC_CLEAR, 5'd0, 16'd0, 16'd0);
    endtask

    task automatic test_first_fit();
        set_reg(fpfa_pkg::REG_HOLE_COUNT, 32'd4);
        set_reg(fpfa_pkg::REG_FIT_POLICY, 32'(fpfa_pkg::POL_FIRST));
        issue(fpfa_pkg::FUNC_LOAD, 5'd0, 16'd0, 16'd0);
        issue(fpfa_pkg::FUNC_LOAD, 5'd1, 16'hFFFF, 16'd0);
        issue(fpfa_pkg::FUNC_LOAD, 5'd2, 16'd100, 16'd0);
        issue(fpfa_pkg::FUNC_LOAD, 5'd3, 16'd100, 16'd0);
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd0);    // zero request takes the empty hole
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd100);
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd100);
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'hFFFF); // only fitting hole is held
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd1);
        issue(fpfa_pkg::FUNC_LOAD, 5'd1, 16'd50, 16'd0);    // reload keeps the held mark
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd0);
        issue(fpfa_pkg::FUNC_CLEAR, 5'd0, 16'd0, 16'd0);
    endtask

    task automatic test_best_fit();
        set_reg(fpfa_pkg::REG_FIT_POLICY, 32'(fpfa_pkg::POL_BEST));
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd100);  // tie, lowest index wins
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd0);
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd60);
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd60);
        issue(fpfa_pkg::FUNC_CLEAR, 5'd0, 16'd0, 16'd0);
    endtask

    task automatic test_worst_fit();
        set_reg(fpfa_pkg::REG_FIT_POLICY, 32'(fpfa_pkg::POL_WORST));
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd0);
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd0);
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd0);
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd0);    // empty hole never eligible
        issue(fpfa_pkg::FUNC_CLEAR, 5'd0, 16'd0, 16'd0);
    endtask

    task automatic test_unused_policy();
        set_reg(fpfa_pkg::REG_FIT_POLICY, 32'(POL_UNUSED));
        issue(fpfa_pkg::FUNC_ALLOC, 5'd0, 16'd0, 16'd0);
    endtask

    // every slot gets a size before any scan can reach it
    task automatic test_fill_holes();
        fpfa_pkg::fpfa_in_t it;
        for (int i = 0; i < HOLES; i++)
        begin
            it = rand_item();
            it.func = fpfa_pkg::FUNC_LOAD;
            it.hole_slot = 5'(i);
            send_item(it);
        end
    endtask

    task automatic test_random_phases();
        logic [1:0] pol;
        logic [5:0] cnt;
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0:
                begin
                    pol = fpfa_pkg::POL_FIRST;
                    cnt = 6'd32;
                end
                1:
                begin
                    pol = fpfa_pkg::POL_BEST;
                    cnt = 6'd63;
                end
                2:
                begin
                    pol = fpfa_pkg::POL_WORST;
                    cnt = 6'd1;
                end
                3:
                begin
                    pol = POL_UNUSED;
                    cnt = 6'd32;
                end
                4:
                begin
                    pol = fpfa_pkg::POL_FIRST;
                    cnt = 6'd0;
                end
                5:
                begin
                    pol = fpfa_pkg::POL_WORST;
                    cnt = 6'd33;
                end
                default:
                begin
                    pol = 2'($urandom_range(0, 2));
                    cnt = 6'($urandom_range(1, 32));
                end
            endcase
            set_reg(fpfa_pkg::REG_FIT_POLICY, 32'(pol));
            set_reg(fpfa_pkg::REG_HOLE_COUNT, 32'(cnt));
            repeat (120) send_item(rand_item());
        end
    endtask

    task automatic test_backpressure();
        set_reg(fpfa_pkg::REG_FIT_POLICY, 32'(fpfa_pkg::POL_BEST));
        set_reg(fpfa_pkg::REG_HOLE_COUNT, 32'd32);
        hold_off = 1'b1;
        repeat (40) send_item(rand_item());
    endtask

    task automatic test_calm_tail();
        set_reg(fpfa_pkg::REG_FIT_POLICY, 32'(fpfa_pkg::POL_WORST));
        set_reg(fpfa_pkg::REG_HOLE_COUNT, 32'd32);
        calm = 1'b1;
        repeat (200) send_item(rand_item());
    endtask

    // result receiver with random stalls and one long hold-off
    initial
    begin
        rsp_ready = 1'b0;
        while (!rst_n)
            @(negedge clk);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                rsp_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_off = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                rsp_ready = 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge clk);
            end
            else
                rsp_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        fpfa_pkg::fpfa_out_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (grant_q.size() == 0)
                report_mismatch($sformatf("result with none expected: found %0d index %0d",
                                          rsp.found, rsp.hole_index));
            else
            begin
                want = grant_q.pop_front();
                if (rsp.found !== want.found)
                    report_mismatch($sformatf("found: got %0d want %0d",
                                              rsp.found, want.found));
                if (rsp.hole_index !== want.hole_index)
                    report_mismatch($sformatf("hole_index: got %0d want %0d",
                                              rsp.hole_index, want.hole_index));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        calm = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_policy = fpfa_pkg::POL_FIRST;
        cur_count = '0;
        held_mask = '0;
        for (int i = 0; i < HOLES; i++)
            hole_sizes[i] = '0;
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_empty_scan();
        test_first_fit();
        test_best_fit();
        test_worst_fit();
        test_unused_policy();
        test_fill_holes();
        test_random_phases();
        test_backpressure();
        test_calm_tail();

        settle();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
